// ----- rtl/dmtm_pkg.sv -----
`timescale 1ns / 1ps

package dmtm_pkg;

  localparam int TASK_ENTRIES = 64;
  localparam int WL_ENTRIES   = 16;

  localparam int TASK_AW = (TASK_ENTRIES > 1) ? $clog2(TASK_ENTRIES) : 1;
  localparam int WL_AW   = (WL_ENTRIES > 1) ? $clog2(WL_ENTRIES) : 1;
  localparam int SCAN_AW = (TASK_AW > WL_AW) ? TASK_AW : WL_AW;
  localparam int SCAN_CW = SCAN_AW + 1;

  localparam int HASH_W  = 64;
  localparam int KEY_W   = 2 * HASH_W;
  localparam int CNT_W   = 32;
  localparam int FT_W    = 8;
  localparam int IN_W    = 168;
  localparam int OUT_W   = 176;

  typedef enum logic [1:0] {
    KIND_EVENT      = 2'd0,
    KIND_SET_LIMIT  = 2'd1,
    KIND_CLR_LIMITS = 2'd2,
    KIND_CLR_ALL    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_TASK_FULL = 2'd1,
    STATUS_WL_FULL   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_T_SCAN,
    ST_T_UPD,
    ST_W_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [HASH_W-1:0] wl_hash;
    logic [HASH_W-1:0] tk_hash;
    logic [CNT_W-1:0]  miss_count;
    logic [CNT_W-1:0]  limit;
  } task_ent_t;

  typedef struct packed {
    logic               done;
    logic               hit;
    logic               free_found;
    logic [SCAN_AW-1:0] hit_idx;
    logic [SCAN_AW-1:0] free_idx;
  } scan_stat_t;

endpackage

// ----- rtl/dmtm_ram.sv -----
`timescale 1ns / 1ps

module dmtm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/dmtm_scan.sv -----
`timescale 1ns / 1ps

module dmtm_scan (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [dmtm_pkg::SCAN_CW-1:0]  depth_i,
  input  logic                          issue_free_i,
  input  logic                          cmp_valid_i,
  input  logic [dmtm_pkg::KEY_W-1:0]    key_rd_i,
  input  logic [dmtm_pkg::KEY_W-1:0]    key_ref_i,
  output logic                          rd_en_o,
  output logic [dmtm_pkg::SCAN_AW-1:0]  rd_addr_o,
  output logic [dmtm_pkg::SCAN_AW-1:0]  cmp_addr_o,
  output dmtm_pkg::scan_stat_t          stat_o
);
  import dmtm_pkg::*;

  logic               act_q, act_d;
  logic               pv_q, pv_d;
  logic               done_q, done_d;
  logic               hit_q, hit_d;
  logic               ff_q, ff_d;
  logic [SCAN_CW-1:0] cnt_q, cnt_d;
  logic [SCAN_AW-1:0] paddr_q, paddr_d;
  logic [SCAN_AW-1:0] hidx_q, hidx_d;
  logic [SCAN_AW-1:0] fidx_q, fidx_d;
  logic               issue_ok;
  logic               match;

  // The read of one entry is issued while the previously read entry is compared.
  assign issue_ok   = act_q && (cnt_q < depth_i);
  assign match      = act_q && pv_q && cmp_valid_i && (key_rd_i == key_ref_i);
  assign rd_en_o    = issue_ok && !match;
  assign rd_addr_o  = cnt_q[SCAN_AW-1:0];
  assign cmp_addr_o = paddr_q;

  always_comb begin
    act_d   = act_q;
    pv_d    = pv_q;
    done_d  = 1'b0;
    hit_d   = hit_q;
    ff_d    = ff_q;
    cnt_d   = cnt_q;
    paddr_d = paddr_q;
    hidx_d  = hidx_q;
    fidx_d  = fidx_q;
    if (start_i) begin
      act_d = 1'b1;
      pv_d  = 1'b0;
      hit_d = 1'b0;
      ff_d  = 1'b0;
      cnt_d = '0;
    end else if (act_q) begin
      if (match) begin
        act_d  = 1'b0;
        pv_d   = 1'b0;
        hit_d  = 1'b1;
        hidx_d = paddr_q;
        done_d = 1'b1;
      end else if (issue_ok) begin
        cnt_d   = cnt_q + SCAN_CW'(1);
        pv_d    = 1'b1;
        paddr_d = cnt_q[SCAN_AW-1:0];
        if (issue_free_i && !ff_q) begin
          ff_d   = 1'b1;
          fidx_d = cnt_q[SCAN_AW-1:0];
        end
      end else begin
        pv_d = 1'b0;
        if (!pv_q) begin
          act_d  = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 1'b0;
      pv_q   <= 1'b0;
      done_q <= 1'b0;
      hit_q  <= 1'b0;
      ff_q   <= 1'b0;
      cnt_q  <= '0;
    end else begin
      act_q  <= act_d;
      pv_q   <= pv_d;
      done_q <= done_d;
      hit_q  <= hit_d;
      ff_q   <= ff_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    paddr_q <= paddr_d;
    hidx_q  <= hidx_d;
    fidx_q  <= fidx_d;
  end

  assign stat_o.done       = done_q;
  assign stat_o.hit        = hit_q;
  assign stat_o.free_found = ff_q;
  assign stat_o.hit_idx    = hidx_q;
  assign stat_o.free_idx   = fidx_q;

endmodule

// ----- rtl/deadline_miss_threshold_monitor_core.sv -----
// Channel    Direction  Payload
// s_axis     in         tuser: kind; tdata: event type, workload key, task key, limit
// m_axis     out        tdata: report, event type, workload key, task key,
//                       miss count, status
// cfg        in         cfg_wdata_i: miss_type_code, written when cfg_we_i is high
//
// A deadline-miss event walks the task table, one entry per cycle through a single
// read port and one shared key comparator, and, when its limit is exceeded, walks the
// workload table the same way before the result is formed. Limit writes walk only the
// task table; other items go straight to the result. Reset clears all valid bits at
// once, so no clearing pass runs.
// An item is taken only while the sequencer is idle; a finished result waits in the
// output register, and the next item is taken while it waits.
`timescale 1ns / 1ps

module deadline_miss_threshold_monitor_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dmtm_pkg::FT_W-1:0]     cfg_wdata_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [7:0] event type, [71:8] workload key, [135:72] task key, [167:136] limit
  input  logic [dmtm_pkg::IN_W-1:0]     s_axis_tdata_i,
  // [1:0] kind
  input  logic [1:0]                    s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [0] report, [8:1] event type, [72:9] workload key,
  // [136:73] task key, [168:137] miss count, [170:169] status, [175:171] zero
  output logic [dmtm_pkg::OUT_W-1:0]    m_axis_tdata_o
);
  import dmtm_pkg::*;

  localparam int TASK_W = $bits(task_ent_t);

  state_e state_q, state_d;

  logic [FT_W-1:0]   code_q;
  kind_e             kind_q, kind_d;
  logic [FT_W-1:0]   ft_q, ft_d;
  logic [HASH_W-1:0] wl_q, wl_d;
  logic [HASH_W-1:0] tk_q, tk_d;
  logic [CNT_W-1:0]  lim_q, lim_d;

  logic              rep_q, rep_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  status_e           st_q, st_d;
  logic              hit_q, hit_d;
  logic [TASK_AW-1:0] slot_q, slot_d;

  logic [TASK_ENTRIES-1:0] task_vld_q, task_vld_d;
  logic [TASK_ENTRIES-1:0] limv_q, limv_d;
  logic [WL_ENTRIES-1:0]   wvld_q, wvld_d;

  logic              mv_q, mv_d;
  logic [OUT_W-1:0]  mdata_q, mdata_d;

  logic              in_acc;
  kind_e             in_kind;
  logic              is_miss_in;
  logic              out_free;
  logic              exceed;
  logic [CNT_W-1:0]  cur_count;
  logic [CNT_W-1:0]  cur_lim;
  logic [CNT_W-1:0]  new_count;

  logic              scan_start;
  logic              wsel;
  logic [SCAN_CW-1:0] scan_depth;
  logic              scan_issue_free;
  logic              scan_cmp_valid;
  logic [KEY_W-1:0]  scan_key_rd;
  logic [KEY_W-1:0]  scan_key_ref;
  logic              scan_rd_en;
  logic [SCAN_AW-1:0] scan_rd_addr;
  logic [SCAN_AW-1:0] scan_cmp_addr;
  scan_stat_t        scan_st;

  logic              task_we;
  task_ent_t         task_wdata;
  task_ent_t         task_rdata;
  logic              wl_we;
  logic [WL_AW-1:0]  wl_waddr;
  logic [HASH_W-1:0] wl_rdata;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign in_kind         = kind_e'(s_axis_tuser_i);
  assign is_miss_in      = (s_axis_tdata_i[FT_W-1:0] == code_q);
  assign out_free        = !mv_q || m_axis_tready_i;

  assign wsel          = (state_q == ST_W_SCAN);
  assign scan_depth    = wsel ? SCAN_CW'(WL_ENTRIES) : SCAN_CW'(TASK_ENTRIES);
  assign scan_issue_free = wsel ? !wvld_q[scan_rd_addr[WL_AW-1:0]]
                                : !task_vld_q[scan_rd_addr[TASK_AW-1:0]];
  assign scan_cmp_valid  = wsel ? wvld_q[scan_cmp_addr[WL_AW-1:0]]
                                : task_vld_q[scan_cmp_addr[TASK_AW-1:0]];
  assign scan_key_rd   = wsel ? {{HASH_W{1'b0}}, wl_rdata}
                              : {task_rdata.wl_hash, task_rdata.tk_hash};
  assign scan_key_ref  = wsel ? {{HASH_W{1'b0}}, wl_q} : {wl_q, tk_q};

  assign cur_count = hit_q ? task_rdata.miss_count : '0;
  assign cur_lim   = (hit_q && limv_q[slot_q]) ? task_rdata.limit : '0;
  assign new_count = (cur_count == {CNT_W{1'b1}}) ? cur_count : cur_count + CNT_W'(1);
  assign exceed    = (cur_lim != '0) && (new_count > cur_lim);

  dmtm_scan u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (scan_start),
    .depth_i      (scan_depth),
    .issue_free_i (scan_issue_free),
    .cmp_valid_i  (scan_cmp_valid),
    .key_rd_i     (scan_key_rd),
    .key_ref_i    (scan_key_ref),
    .rd_en_o      (scan_rd_en),
    .rd_addr_o    (scan_rd_addr),
    .cmp_addr_o   (scan_cmp_addr),
    .stat_o       (scan_st)
  );

  dmtm_ram #(.Width(TASK_W), .Depth(TASK_ENTRIES)) u_task_ram (
    .clk_i   (clk_i),
    .we_i    (task_we),
    .waddr_i (slot_q),
    .wdata_i (task_wdata),
    .re_i    (scan_rd_en && !wsel),
    .raddr_i (scan_rd_addr[TASK_AW-1:0]),
    .rdata_o (task_rdata)
  );

  dmtm_ram #(.Width(HASH_W), .Depth(WL_ENTRIES)) u_wl_ram (
    .clk_i   (clk_i),
    .we_i    (wl_we),
    .waddr_i (wl_waddr),
    .wdata_i (wl_q),
    .re_i    (scan_rd_en && wsel),
    .raddr_i (scan_rd_addr[WL_AW-1:0]),
    .rdata_o (wl_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_kind)
            KIND_EVENT:     state_d = is_miss_in ? ST_T_SCAN : ST_DONE;
            KIND_SET_LIMIT: state_d = ST_T_SCAN;
            default:        state_d = ST_DONE;
          endcase
        end
      end
      ST_T_SCAN: begin
        if (scan_st.done) begin
          state_d = (scan_st.hit || scan_st.free_found) ? ST_T_UPD : ST_DONE;
        end
      end
      ST_T_UPD: begin
        state_d = ((kind_q == KIND_EVENT) && exceed) ? ST_W_SCAN : ST_DONE;
      end
      ST_W_SCAN: begin
        if (scan_st.done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    kind_d     = kind_q;
    ft_d       = ft_q;
    wl_d       = wl_q;
    tk_d       = tk_q;
    lim_d      = lim_q;
    rep_d      = rep_q;
    cnt_d      = cnt_q;
    st_d       = st_q;
    hit_d      = hit_q;
    slot_d     = slot_q;
    task_vld_d = task_vld_q;
    limv_d     = limv_q;
    wvld_d     = wvld_q;
    mv_d       = mv_q;
    mdata_d    = mdata_q;
    scan_start = 1'b0;
    task_we    = 1'b0;
    task_wdata = '{wl_hash: wl_q, tk_hash: tk_q, miss_count: cur_count, limit: lim_q};
    wl_we      = 1'b0;
    wl_waddr   = scan_st.free_idx[WL_AW-1:0];

    if (mv_q && m_axis_tready_i) begin
      mv_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          kind_d = in_kind;
          ft_d   = s_axis_tdata_i[7:0];
          wl_d   = s_axis_tdata_i[71:8];
          tk_d   = s_axis_tdata_i[135:72];
          lim_d  = s_axis_tdata_i[167:136];
          rep_d  = 1'b0;
          cnt_d  = '0;
          st_d   = STATUS_OK;
          unique case (in_kind)
            KIND_EVENT: begin
              if (is_miss_in) begin
                scan_start = 1'b1;
              end else begin
                rep_d = 1'b1;
              end
            end
            KIND_SET_LIMIT:  scan_start = 1'b1;
            KIND_CLR_LIMITS: limv_d = '0;
            default: begin
              task_vld_d = '0;
              wvld_d     = '0;
            end
          endcase
        end
      end
      ST_T_SCAN: begin
        if (scan_st.done) begin
          hit_d  = scan_st.hit;
          slot_d = scan_st.hit ? scan_st.hit_idx[TASK_AW-1:0]
                               : scan_st.free_idx[TASK_AW-1:0];
          if (!scan_st.hit && !scan_st.free_found) begin
            st_d = STATUS_TASK_FULL;
          end
        end
      end
      ST_T_UPD: begin
        task_we            = 1'b1;
        task_vld_d[slot_q] = 1'b1;
        limv_d[slot_q]     = 1'b1;
        if (kind_q == KIND_EVENT) begin
          task_wdata.miss_count = new_count;
          task_wdata.limit      = cur_lim;
          cnt_d                 = new_count;
          if (exceed) begin
            scan_start = 1'b1;
          end
        end
      end
      ST_W_SCAN: begin
        if (scan_st.done && !scan_st.hit) begin
          rep_d = 1'b1;
          if (scan_st.free_found) begin
            wl_we            = 1'b1;
            wvld_d[wl_waddr] = 1'b1;
          end else begin
            st_d = STATUS_WL_FULL;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          mv_d    = 1'b1;
          mdata_d = {5'b0, st_q, cnt_q, tk_q, wl_q, ft_q, rep_q};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      code_q     <= '0;
      task_vld_q <= '0;
      limv_q     <= '0;
      wvld_q     <= '0;
      mv_q       <= 1'b0;
      st_q       <= STATUS_OK;
      rep_q      <= 1'b0;
      hit_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      if (cfg_we_i) begin
        code_q <= cfg_wdata_i;
      end
      task_vld_q <= task_vld_d;
      limv_q     <= limv_d;
      wvld_q     <= wvld_d;
      mv_q       <= mv_d;
      st_q       <= st_d;
      rep_q      <= rep_d;
      hit_q      <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    ft_q    <= ft_d;
    wl_q    <= wl_d;
    tk_q    <= tk_d;
    lim_q   <= lim_d;
    cnt_q   <= cnt_d;
    slot_q  <= slot_d;
    mdata_q <= mdata_d;
  end

  assign m_axis_tvalid_o = mv_q;
  assign m_axis_tdata_o  = mdata_q;

  a_no_task_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    task_we |-> !(scan_rd_en && !wsel))
    else $error("task table written while the walk reads it");

  a_hit_is_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_T_SCAN) && scan_st.done && scan_st.hit
      |-> task_vld_q[scan_st.hit_idx[TASK_AW-1:0]])
    else $error("task walk matched an entry that is not valid");

  a_wl_alloc_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wl_we |-> !wvld_q[wl_waddr])
    else $error("workload mark written over a valid entry");

  a_full_no_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[170:169] == STATUS_TASK_FULL)
      |-> !m_axis_tdata_o[0])
    else $error("event reported although the task table was full");

endmodule
